// ===== sv/gfit_pkg.sv =====
// ----------------------------------------------------------------------------
// gfit_pkg
// Shared types, constants and helpers of the grid first-fit placement unit.
// ----------------------------------------------------------------------------
package gfit_pkg;

   localparam int MAX_COLUMNS = 16;
   localparam int MAX_ROWS    = 16;

   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int GRID_DEPTH = 1 << ADDR_W;

   localparam int DIM_W   = 5;          // rectangle sides and grid extents
   localparam int TAG_W   = 8;
   localparam int POS_W   = 4;
   localparam int FREE_W  = 9;
   localparam int AREA_W  = 2 * DIM_W;
   localparam int BND_W   = 8;          // room for a position plus a side
   localparam int CSR_IDX_W = 1;

   localparam logic [TAG_W-1:0] EMPTY_CELL = 8'hff;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 1'b1;

   localparam logic FUNC_PLACE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SPOT,
      ST_SCAN,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             func;
      logic [DIM_W-1:0] item_width;
      logic [DIM_W-1:0] item_height;
      logic [TAG_W-1:0] owner_tag;
   } req_data_type;

   typedef struct packed {
      logic              placed;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic              rotated;
      logic [FREE_W-1:0] free_cells;
   } rsp_data_type;

   // Limit a configured extent to 1..max_v.
   function automatic logic [DIM_W-1:0] clamp_extent(input logic [DIM_W-1:0] v,
                                                     input int max_v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_v) begin
         r = DIM_W'(max_v);
      end
      return r;
   endfunction

endpackage

// ===== sv/gfit_chan_if.sv =====
// ----------------------------------------------------------------------------
// gfit_req_if / gfit_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface gfit_req_if;
   import gfit_pkg::*;

   logic         valid;
   logic         ready;
   req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gfit_rsp_if;
   import gfit_pkg::*;

   logic         valid;
   logic         ready;
   rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/grid_rectangle_first_fit_unit.sv =====
// ----------------------------------------------------------------------------
// grid_rectangle_first_fit_unit
// First-fit placement of rectangles on a grid of 8-bit cells held in RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  req_if  | in  | valid/ready        | func, item_width, item_height, tag
//  rsp_if  | out | valid/ready        | placed, pos_x, pos_y, rotated, free
//  csr_*   | in  | write enable only  | index 0 columns, 1 rows (5 bits)
//
//  A clear transaction goes straight from the request to the response. A
//  place transaction first sweeps the area in use to count free cells (one
//  RAM read per cycle), then, if enough are free, tries each candidate
//  spot, unrotated and then rotated: a bounds check, then cell reads until
//  a taken cell is met, then writes of the w x h cells on a fit, then the
//  loading of the response. Reset is synchronous and marks every cell empty
//  at once through per-cell valid bits; no clearing pass is needed. A
//  stalled response holds in its output register while the next request is
//  taken and worked on; the unit then waits in its final state for the slot.
//
module grid_rectangle_first_fit_unit (
   input  logic                               clock,
   input  logic                               reset,
   gfit_req_if.sink                           req_if,
   gfit_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [gfit_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gfit_pkg::DIM_W-1:0]         csr_wdata
);
   import gfit_pkg::*;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [DIM_W-1:0]     cols_ff, rows_ff;
   logic [DIM_W-1:0]     w_ff, w_in, h_ff, h_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [AREA_W-1:0]    area_ff, area_in;
   logic [FREE_W-1:0]    cnt_ff, cnt_in;
   logic [COL_W-1:0]     pos_x_ff, pos_x_in, cur_x_ff, cur_x_in;
   logic [ROW_W-1:0]     pos_y_ff, pos_y_in, cur_y_ff, cur_y_in;
   logic                 rot_ff, rot_in;
   logic                 placed_ff, placed_in;
   logic                 clr_ff, clr_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_data_type         rsp_data_ff, rsp_data_in;

   // Cell store: data in RAM, per-cell valid bits in flops
   logic [TAG_W-1:0]      grid_mem [GRID_DEPTH];
   logic [GRID_DEPTH-1:0] cell_vld_ff;
   logic [TAG_W-1:0]      rd_data_ff;
   logic                  rd_vld_ff;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic                  wr_en, clr_grid;

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]  cols_use, rows_use, dw, dh;
   logic [BND_W-1:0]  rect_x_end, rect_y_end;
   logic              fits_bounds, zero_dim, cell_empty;
   logic              cnt_row_end, cnt_last, rect_row_end, rect_last, pos_last;
   logic              req_fire, out_free;
   logic [FREE_W-1:0] cnt_total;
   logic [AREA_W-1:0] grid_area;

   assign cols_use = clamp_extent(cols_ff, MAX_COLUMNS);
   assign rows_use = clamp_extent(rows_ff, MAX_ROWS);

   // Swap sides when trying the rotated rectangle
   assign dw = rot_ff ? h_ff : w_ff;
   assign dh = rot_ff ? w_ff : h_ff;

   assign rect_x_end  = BND_W'(pos_x_ff) + BND_W'(dw);
   assign rect_y_end  = BND_W'(pos_y_ff) + BND_W'(dh);
   assign fits_bounds = (rect_x_end <= BND_W'(cols_use)) && (rect_y_end <= BND_W'(rows_use));
   assign zero_dim    = (dw == '0) || (dh == '0);

   // Read data always belongs to the current cursor cell
   assign cell_empty = !rd_vld_ff || (rd_data_ff == EMPTY_CELL);

   assign cnt_row_end  = (BND_W'(cur_x_ff) + BND_W'(1)) == BND_W'(cols_use);
   assign cnt_last     = cnt_row_end && ((BND_W'(cur_y_ff) + BND_W'(1)) == BND_W'(rows_use));
   assign rect_row_end = (BND_W'(cur_x_ff) + BND_W'(1)) == rect_x_end;
   assign rect_last    = rect_row_end && ((BND_W'(cur_y_ff) + BND_W'(1)) == rect_y_end);
   assign pos_last     = ((BND_W'(pos_x_ff) + BND_W'(1)) == BND_W'(cols_use)) &&
                         ((BND_W'(pos_y_ff) + BND_W'(1)) == BND_W'(rows_use));

   assign cnt_total = cnt_ff + FREE_W'(cell_empty);
   assign grid_area = AREA_W'(cols_use) * AREA_W'(rows_use);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_vld_ff || rsp_if.ready;

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_if.data.func == FUNC_CLEAR) ? ST_DONE : ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (cnt_last) begin
               state_in = (AREA_W'(cnt_total) >= area_ff) ? ST_SPOT : ST_DONE;
            end
         end
         ST_SPOT: begin
            if (fits_bounds) begin
               state_in = zero_dim ? ST_DONE : ST_SCAN;
            end else if (rot_ff && pos_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (!cell_empty) begin
               state_in = (rot_ff && pos_last) ? ST_DONE : ST_SPOT;
            end else if (rect_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (rect_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      w_in        = w_ff;
      h_in        = h_ff;
      tag_in      = tag_ff;
      area_in     = area_ff;
      cnt_in      = cnt_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      rot_in      = rot_ff;
      placed_in   = placed_ff;
      clr_in      = clr_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_if.ready;
      rsp_data_in = rsp_data_ff;
      wr_en       = 1'b0;
      clr_grid    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Latch the request and park every cursor at the origin
               w_in      = req_if.data.item_width;
               h_in      = req_if.data.item_height;
               tag_in    = req_if.data.owner_tag;
               area_in   = AREA_W'(req_if.data.item_width) * AREA_W'(req_if.data.item_height);
               cnt_in    = '0;
               pos_x_in  = '0;
               pos_y_in  = '0;
               cur_x_in  = '0;
               cur_y_in  = '0;
               rot_in    = 1'b0;
               clr_in    = (req_if.data.func == FUNC_CLEAR);
               placed_in = (req_if.data.func == FUNC_CLEAR);
               clr_grid  = (req_if.data.func == FUNC_CLEAR);
            end
         end
         ST_COUNT: begin
            // Sweep the area in use, one cell a cycle
            cnt_in = cnt_total;
            if (cnt_row_end) begin
               cur_x_in = '0;
               cur_y_in = ROW_W'(cur_y_ff + 1'b1);
            end else begin
               cur_x_in = COL_W'(cur_x_ff + 1'b1);
            end
            if (cnt_last) begin
               cur_x_in = pos_x_ff;
               cur_y_in = pos_y_ff;
            end
         end
         ST_SPOT: begin
            if (fits_bounds) begin
               cur_x_in  = pos_x_ff;
               cur_y_in  = pos_y_ff;
               placed_in = zero_dim;
            end else if (!rot_ff) begin
               rot_in = 1'b1;
            end else begin
               rot_in = 1'b0;
               if ((BND_W'(pos_x_ff) + BND_W'(1)) == BND_W'(cols_use)) begin
                  pos_x_in = '0;
                  pos_y_in = ROW_W'(pos_y_ff + 1'b1);
               end else begin
                  pos_x_in = COL_W'(pos_x_ff + 1'b1);
               end
            end
         end
         ST_SCAN: begin
            if (!cell_empty) begin
               // Taken cell: drop this candidate, try the next
               if (!rot_ff) begin
                  rot_in = 1'b1;
               end else begin
                  rot_in = 1'b0;
                  if ((BND_W'(pos_x_ff) + BND_W'(1)) == BND_W'(cols_use)) begin
                     pos_x_in = '0;
                     pos_y_in = ROW_W'(pos_y_ff + 1'b1);
                  end else begin
                     pos_x_in = COL_W'(pos_x_ff + 1'b1);
                  end
               end
            end else if (rect_last) begin
               // Whole spot is empty: rewind the cursor for the fill
               placed_in = 1'b1;
               cur_x_in  = pos_x_ff;
               cur_y_in  = pos_y_ff;
            end else if (rect_row_end) begin
               cur_x_in = pos_x_ff;
               cur_y_in = ROW_W'(cur_y_ff + 1'b1);
            end else begin
               cur_x_in = COL_W'(cur_x_ff + 1'b1);
            end
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (rect_row_end) begin
               cur_x_in = pos_x_ff;
               cur_y_in = ROW_W'(cur_y_ff + 1'b1);
            end else begin
               cur_x_in = COL_W'(cur_x_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in             = 1'b1;
               rsp_data_in.placed     = placed_ff;
               rsp_data_in.pos_x      = placed_ff ? POS_W'(pos_x_ff) : '0;
               rsp_data_in.pos_y      = placed_ff ? POS_W'(pos_y_ff) : '0;
               rsp_data_in.rotated    = placed_ff && !clr_ff && rot_ff;
               // Placed cells were all empty and inside the area
               if (clr_ff) begin
                  rsp_data_in.free_cells = FREE_W'(grid_area);
               end else if (placed_ff && (tag_ff != EMPTY_CELL)) begin
                  rsp_data_in.free_cells = cnt_ff - FREE_W'(area_ff);
               end else begin
                  rsp_data_in.free_cells = cnt_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = {cur_y_in, cur_x_in};
   assign wr_addr = {cur_y_ff, cur_x_ff};

   // ---------------------------------------------------------------------
   // Cell RAM: one write and one registered read per cycle
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= tag_ff;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr_grid) begin
         cell_vld_ff <= '0;
      end else if (wr_en) begin
         cell_vld_ff[wr_addr] <= 1'b1;
      end
      rd_vld_ff <= cell_vld_ff[rd_addr];
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cols_ff    <= DIM_W'(16);
         rows_ff    <= DIM_W'(16);
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_COLUMNS: cols_ff <= csr_wdata;
               CSR_GRID_ROWS:    rows_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      tag_ff      <= tag_in;
      area_ff     <= area_in;
      cnt_ff      <= cnt_in;
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      rot_ff      <= rot_in;
      placed_ff   <= placed_in;
      clr_ff      <= clr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
